### design/u16u8_pkg.sv
package u16u8_pkg;

    localparam logic [15:0] CAP_RESET       = 16'd256;
    localparam logic [16:0] NEED_MAX        = 17'h1FFFF;
    localparam int          MAX_BYTES       = 6;

    localparam logic [20:0] REPL_CP         = 21'h00FFFD;
    localparam logic [20:0] SUPP_BASE       = 21'h010000;
    localparam logic [20:0] ONE_BYTE_LIMIT  = 21'h000080;
    localparam logic [20:0] TWO_BYTE_LIMIT  = 21'h000800;
    localparam logic [20:0] BMP_LIMIT       = 21'h010000;

    localparam logic [15:0] HI_FIRST        = 16'hD800;
    localparam logic [15:0] HI_LAST         = 16'hDBFF;
    localparam logic [15:0] LO_FIRST        = 16'hDC00;
    localparam logic [15:0] LO_LAST         = 16'hDFFF;

    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] b;
    } utf8_seq_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                nbytes;
        logic                      has_end;
        logic                      term;
        logic [16:0]               needed;
        logic [15:0]               stored;
        logic                      ranout;
    } batch_t;

    function automatic utf8_seq_t encode_cp(input logic [20:0] cp);
        utf8_seq_t s;
        s = '0;
        if (cp < ONE_BYTE_LIMIT)
        begin
            s.n    = 3'd1;
            s.b[0] = {1'b0, cp[6:0]};
        end
        else if (cp < TWO_BYTE_LIMIT)
        begin
            s.n    = 3'd2;
            s.b[0] = {3'b110, cp[10:6]};
            s.b[1] = {2'b10, cp[5:0]};
        end
        else if (cp < BMP_LIMIT)
        begin
            s.n    = 3'd3;
            s.b[0] = {4'b1110, cp[15:12]};
            s.b[1] = {2'b10, cp[11:6]};
            s.b[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            s.n    = 3'd4;
            s.b[0] = {5'b11110, cp[20:18]};
            s.b[1] = {2'b10, cp[17:12]};
            s.b[2] = {2'b10, cp[11:6]};
            s.b[3] = {2'b10, cp[5:0]};
        end
        return s;
    endfunction

endpackage

### design/u16u8_core.sv
module u16u8_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata,
    output logic                  batch_load,
    output u16u8_pkg::batch_t     batch,
    input  logic                  batch_take
);
    import u16u8_pkg::*;

    typedef struct packed {
        logic [15:0] stored;
        logic [16:0] needed;
        logic        full;
        logic        store;
    } step_t;

    function automatic step_t emit_step(input logic [15:0] stored, input logic [16:0] needed,
                                        input logic full, input logic emit,
                                        input logic [2:0] n, input logic [15:0] cap);
        step_t       r;
        logic [17:0] need_sum;
        logic        fit;
        need_sum = {1'b0, needed} + {15'd0, n};
        fit      = !full && (({2'b00, stored} + {15'd0, n} + 18'd1) <= {2'b00, cap});
        r.store  = emit && fit;
        r.full   = full || (emit && !fit);
        r.stored = r.store ? stored + {13'd0, n} : stored;
        if (!emit)
            r.needed = needed;
        else if (need_sum > {1'b0, NEED_MAX})
            r.needed = NEED_MAX;
        else
            r.needed = need_sum[16:0];
        return r;
    endfunction

    logic        in_valid_reg;
    logic [15:0] unit_reg;
    logic        ranout_reg;
    logic [15:0] cap_reg;
    logic [9:0]  pending_high_reg;
    logic        pending_valid_reg;
    logic [15:0] stored_reg;
    logic [16:0] needed_reg;
    logic        full_reg;

    logic [9:0]  pending_high_next;
    logic        pending_valid_next;
    logic [15:0] stored_next;
    logic [16:0] needed_next;
    logic        full_next;

    logic        advance;
    logic        have;
    logic        is_low;
    logic        is_high;
    logic        pair;
    logic        emit2;
    logic        str_end;
    logic [20:0] cp1;
    logic [20:0] cp2;
    utf8_seq_t   seq1;
    utf8_seq_t   seq2;
    step_t       st1;
    step_t       st2;
    logic [2:0]  n1s;
    logic [2:0]  n2s;

    assign s_tready = !in_valid_reg || batch_take;
    assign advance  = in_valid_reg && batch_take;

    assign have    = !ranout_reg && (unit_reg != 16'd0);
    assign is_low  = unit_reg inside {[LO_FIRST:LO_LAST]};
    assign is_high = unit_reg inside {[HI_FIRST:HI_LAST]};
    assign pair    = pending_valid_reg && have && is_low;
    assign emit2   = have && !pair && !is_high;
    assign str_end = !have;

    assign cp1  = pair ? SUPP_BASE + {1'b0, pending_high_reg, unit_reg[9:0]} : REPL_CP;
    assign cp2  = is_low ? REPL_CP : {5'd0, unit_reg};
    assign seq1 = encode_cp(cp1);
    assign seq2 = encode_cp(cp2);

    assign st1 = emit_step(stored_reg, needed_reg, full_reg, pending_valid_reg, seq1.n, cap_reg);
    assign st2 = emit_step(st1.stored, st1.needed, st1.full, emit2, seq2.n, cap_reg);

    assign n1s = st1.store ? seq1.n : 3'd0;
    assign n2s = st2.store ? seq2.n : 3'd0;

    always_comb
    begin
        logic [2:0] j;
        batch = '0;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            j = 3'(i) - n1s;
            if (3'(i) < n1s)
                batch.bytes[i] = seq1.b[i[1:0]];
            else if (j < n2s)
                batch.bytes[i] = seq2.b[j[1:0]];
            else
                batch.bytes[i] = 8'd0;
        end
        batch.nbytes  = n1s + n2s;
        batch.has_end = str_end;
        batch.term    = ({1'b0, st2.stored} + 17'd1) <= {1'b0, cap_reg};
        batch.needed  = st2.needed;
        batch.stored  = st2.stored;
        batch.ranout  = ranout_reg;
    end

    assign batch_load = advance && ((batch.nbytes != 3'd0) || str_end);

    always_comb
    begin
        if (str_end)
        begin
            pending_high_next  = '0;
            pending_valid_next = 1'b0;
            stored_next        = '0;
            needed_next        = '0;
            full_next          = 1'b0;
        end
        else
        begin
            pending_valid_next = have && !pair && is_high;
            pending_high_next  = pending_valid_next ? unit_reg[9:0] : 10'd0;
            stored_next        = st2.stored;
            needed_next        = st2.needed;
            full_next          = st2.full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            cap_reg           <= CAP_RESET;
            pending_high_reg  <= '0;
            pending_valid_reg <= 1'b0;
            stored_reg        <= '0;
            needed_reg        <= '0;
            full_reg          <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (advance)
            begin
                pending_high_reg  <= pending_high_next;
                pending_valid_reg <= pending_valid_next;
                stored_reg        <= stored_next;
                needed_reg        <= needed_next;
                full_reg          <= full_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            unit_reg   <= s_tdata;
            ranout_reg <= s_tuser;
        end
    end

    a_needed_covers_stored: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, stored_reg} <= needed_reg)
        else $error("needed count below stored count");

    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && !(advance && str_end) |=> full_reg)
        else $error("store full flag dropped inside a string");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && str_end |=> !pending_valid_reg && stored_reg == 16'd0 && !full_reg)
        else $error("string state not cleared after end");

    a_no_store_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        advance && full_reg |-> batch.nbytes == 3'd0)
        else $error("bytes stored after capacity miss");

endmodule

### design/u16u8_ser.sv
module u16u8_ser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              batch_load,
    input  u16u8_pkg::batch_t batch,
    output logic              batch_take,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);
    import u16u8_pkg::*;

    batch_t     batch_reg;
    logic       valid_reg;
    logic [2:0] idx_reg;
    logic [2:0] total;
    logic       end_word;
    logic       fire;

    assign total    = batch_reg.nbytes + {2'b00, batch_reg.has_end};
    assign end_word = batch_reg.has_end && (idx_reg == batch_reg.nbytes);
    assign fire     = m_tvalid && m_tready;

    assign m_tvalid   = valid_reg;
    assign m_tlast    = idx_reg == (total - 3'd1);
    assign m_tuser    = end_word;
    assign batch_take = !valid_reg || (fire && m_tlast);

    always_comb
    begin
        m_tdata = '0;
        if (end_word)
        begin
            m_tdata[8]     = batch_reg.term;
            m_tdata[25:9]  = batch_reg.needed;
            m_tdata[41:26] = batch_reg.stored;
            m_tdata[42]    = batch_reg.ranout;
        end
        else
        begin
            m_tdata[7:0] = batch_reg.bytes[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (batch_take)
        begin
            valid_reg <= batch_load;
            idx_reg   <= '0;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (batch_take && batch_load)
            batch_reg <= batch;
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> idx_reg < total)
        else $error("word index past end of batch");

    a_batch_continues: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !m_tlast |=> m_tvalid && idx_reg == $past(idx_reg) + 3'd1)
        else $error("batch cut short");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end record not last word of item");

endmodule

### design/utf16le_to_utf8_transcoder.sv
// Channel   Dir  Handshake            Contents
// s_*       in   s_tvalid/s_tready    tdata: code_unit; tuser: span_ended
// m_*       out  m_tvalid/m_tready    tdata: out_byte, terminator_written, needed_total,
//                                     stored_total, ran_out; tlast; tuser: string_end
// cfg_*     in   cfg_we               cfg_wdata: dest_capacity
//
// One output word per cycle unless m_tready stalls; an item yields up to 6 words.
// The byte-wide serializer sets the pace; the encoder takes one item a cycle unless held.
// Each item passes the input register, then the batch register, before its first word.
// Reset clears the string state and sets capacity to 256.
// A stall on m_tready holds the batch; the input register keeps one more item meanwhile.
module utf16le_to_utf8_transcoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    input  logic        s_tuser,   // [0] span_ended
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] out_byte, [8] terminator_written,
                                   // [25:9] needed_total, [41:26] stored_total,
                                   // [42] ran_out, [47:43] zero
    output logic        m_tlast,   // last_of_item
    output logic        m_tuser,   // [0] string_end
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import u16u8_pkg::*;

    batch_t batch;
    logic   batch_load;
    logic   batch_take;

    u16u8_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .batch_load (batch_load),
        .batch      (batch),
        .batch_take (batch_take)
    );

    u16u8_ser u_ser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .batch_load (batch_load),
        .batch      (batch),
        .batch_take (batch_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

### tb/sv/utf8_stream_checker.sv
`timescale 1ns / 1ps

module utf8_stream_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          mismatches,
    output int          due_count
);
    import u16u8_pkg::*;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        str_end;
        logic        term;
        logic [16:0] need;
        logic [15:0] stored;
        logic        ranout;
    } utf8_word_t;

    utf8_word_t  utf8_due [$];
    logic [15:0] capacity;
    logic [9:0]  held_hi;
    logic        held_ok;
    logic [15:0] stored_n;
    logic [16:0] need_n;
    logic        full;
    int          produced;

    task automatic clear_string();
        held_hi  = '0;
        held_ok  = 1'b0;
        stored_n = '0;
        need_n   = '0;
        full     = 1'b0;
    endtask

    task automatic encode_and_store(input logic [20:0] cp);
        logic [3:0][7:0] seq;
        logic [17:0]     sum;
        utf8_word_t      w;
        int              n;
        seq = '0;
        if (cp < 21'h80)
        begin
            n = 1;
            seq[0] = cp[7:0];
        end
        else if (cp < 21'h800)
        begin
            n = 2;
            seq[0] = 8'hC0 | 8'(cp >> 6);
            seq[1] = 8'h80 | 8'(cp & 21'h3F);
        end
        else if (cp < 21'h10000)
        begin
            n = 3;
            seq[0] = 8'hE0 | 8'(cp >> 12);
            seq[1] = 8'h80 | 8'((cp >> 6) & 21'h3F);
            seq[2] = 8'h80 | 8'(cp & 21'h3F);
        end
        else
        begin
            n = 4;
            seq[0] = 8'hF0 | 8'((cp >> 18) & 21'h7);
            seq[1] = 8'h80 | 8'((cp >> 12) & 21'h3F);
            seq[2] = 8'h80 | 8'((cp >> 6) & 21'h3F);
            seq[3] = 8'h80 | 8'(cp & 21'h3F);
        end
        sum = {1'b0, need_n} + 18'(n);
        need_n = (sum > {1'b0, NEED_MAX}) ? NEED_MAX : sum[16:0];
        if (full || int'(stored_n) + n + 1 > int'(capacity))
        begin
            full = 1'b1;
        end
        else
        begin
            for (int j = 0; j < n; j++)
            begin
                w = '0;
                w.data = seq[j];
                utf8_due.push_back(w);
            end
            stored_n = stored_n + 16'(n);
            produced = produced + n;
        end
    endtask

    task automatic predict_item(input logic [15:0] code, input logic ended);
        logic       present;
        logic [20:0] cp;
        utf8_word_t w;
        present  = !ended && code != 16'd0;
        produced = 0;
        if (held_ok)
        begin
            if (present && code >= LO_FIRST && code <= LO_LAST)
            begin
                cp = SUPP_BASE + {1'b0, held_hi, 10'b0} + 21'(code - LO_FIRST);
                present = 1'b0;
            end
            else
            begin
                cp = REPL_CP;
            end
            held_ok = 1'b0;
            held_hi = '0;
            encode_and_store(cp);
        end
        if (present)
        begin
            if (code >= HI_FIRST && code <= HI_LAST)
            begin
                held_hi = code[9:0];
                held_ok = 1'b1;
            end
            else if (code >= LO_FIRST && code <= LO_LAST)
                encode_and_store(REPL_CP);
            else
                encode_and_store({5'b0, code});
        end
        if (ended || code == 16'd0)
        begin
            w = '0;
            w.str_end = 1'b1;
            w.term    = (int'(stored_n) + 1 <= int'(capacity));
            w.need    = need_n;
            w.stored  = stored_n;
            w.ranout  = ended;
            utf8_due.push_back(w);
            produced++;
            clear_string();
        end
        if (produced > 0)
            utf8_due[utf8_due.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(input string field, input logic [16:0] want,
                               input logic [16:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_word();
        utf8_word_t want;
        if (utf8_due.size() == 0)
        begin
            $display("%0t: unexpected word, expected none, actual tdata %0h tlast %0b tuser %0b",
                     $time, m_tdata, m_tlast, m_tuser);
            mismatches++;
        end
        else
        begin
            want = utf8_due.pop_front();
            check_field("out_byte", 17'(want.data), 17'(m_tdata[7:0]));
            check_field("last_of_item", 17'(want.last), 17'(m_tlast));
            check_field("string_end", 17'(want.str_end), 17'(m_tuser));
            check_field("terminator_written", 17'(want.term), 17'(m_tdata[8]));
            check_field("needed_total", want.need, m_tdata[25:9]);
            check_field("stored_total", 17'(want.stored), 17'(m_tdata[41:26]));
            check_field("ran_out", 17'(want.ranout), 17'(m_tdata[42]));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity = CAP_RESET;
            clear_string();
            utf8_due.delete();
            mismatches = 0;
            due_count <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                compare_word();
            if (s_tvalid && s_tready)
                predict_item(s_tdata, s_tuser);
            if (cfg_we)
                capacity = cfg_wdata;
            due_count <= utf8_due.size();
        end
    end

endmodule

### tb/sv/utf16le_to_utf8_transcoder_tb.sv
`timescale 1ns / 1ps

module utf16le_to_utf8_transcoder_tb;
    import u16u8_pkg::*;

    localparam int RUN_LIMIT = 1000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          mismatches;
    int          due_count;
    int          cycles = 0;
    bit          calm = 1'b0;
    bit          stall_req = 1'b0;

    utf16le_to_utf8_transcoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    utf8_stream_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .due_count  (due_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("** utf16le_to_utf8_transcoder: FAILED **");
            $finish;
        end
    end

    // hold off the receiver on request, otherwise stall at random
    always @(posedge clk)
    begin
        if (stall_req)
        begin
            stall_req = 1'b0;
            m_tready <= 1'b0;
            repeat (300) @(posedge clk);
        end
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 20);
    end

    task automatic offer_unit(input logic [15:0] code, input logic ended);
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= ended;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (due_count != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic offer_random_text(input int count);
        int sent;
        int pick;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                if ($urandom_range(0, 3) == 0)
                    offer_unit(16'($urandom), 1'b1);
                else
                    offer_unit(16'd0, 1'b0);
            end
            else if (pick < 30)
                offer_unit(16'($urandom_range(1, 16'h7F)), 1'b0);
            else if (pick < 45)
                offer_unit(16'($urandom_range(16'h80, 16'h7FF)), 1'b0);
            else if (pick < 60)
                offer_unit(16'($urandom_range(16'h800, 16'hFFFF)), 1'b0);
            else if (pick < 85)
            begin
                offer_unit(16'($urandom_range(HI_FIRST, HI_LAST)), 1'b0);
                offer_unit(16'($urandom_range(LO_FIRST, LO_LAST)), 1'b0);
                sent++;
            end
            else if (pick < 90)
            begin
                offer_unit(16'($urandom_range(HI_FIRST, HI_LAST)), 1'b0);
                offer_unit(16'($urandom), 1'b0);
                sent++;
            end
            else if (pick < 95)
                offer_unit(16'($urandom_range(LO_FIRST, LO_LAST)), 1'b0);
            else
                offer_unit(16'($urandom), 1'b0);
            sent++;
        end
    endtask

    initial
    begin
        logic [15:0] cap_val;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // code point boundaries and surrogate handling at reset capacity
        offer_unit(16'h0001, 1'b0);
        offer_unit(16'h007F, 1'b0);
        offer_unit(16'h0080, 1'b0);
        offer_unit(16'h07FF, 1'b0);
        offer_unit(16'h0800, 1'b0);
        offer_unit(16'hFFFF, 1'b0);
        offer_unit(HI_FIRST, 1'b0);
        offer_unit(LO_FIRST, 1'b0);
        offer_unit(HI_LAST, 1'b0);
        offer_unit(LO_LAST, 1'b0);
        offer_unit(LO_FIRST, 1'b0);
        offer_unit(16'hD801, 1'b0);
        offer_unit(16'h0041, 1'b0);
        offer_unit(HI_FIRST, 1'b0);
        offer_unit(16'h0800, 1'b0);
        offer_unit(HI_FIRST, 1'b0);
        offer_unit(HI_FIRST, 1'b0);
        offer_unit(16'h0000, 1'b0);
        offer_unit(16'hD83D, 1'b0);
        offer_unit(16'h0041, 1'b1);
        offer_unit(16'hFFFF, 1'b1);
        offer_unit(16'h0000, 1'b0);
        drain_results();

        // tight capacities
        write_capacity(16'd0);
        offer_unit(16'h0041, 1'b0);
        offer_unit(16'h0000, 1'b0);
        drain_results();
        write_capacity(16'd1);
        offer_unit(16'h0041, 1'b0);
        offer_unit(16'h0000, 1'b0);
        drain_results();
        write_capacity(16'd4);
        offer_unit(16'h0800, 1'b0);
        offer_unit(16'h0041, 1'b0);
        offer_unit(16'h0000, 1'b0);
        drain_results();
        write_capacity(16'd3);
        offer_unit(16'h0041, 1'b0);
        offer_unit(16'h0041, 1'b0);
        drain_results();
        write_capacity(16'd2);
        offer_unit(16'h0000, 1'b0);
        drain_results();

        // back up the output while the input keeps offering
        write_capacity(16'hFFFF);
        calm = 1'b1;
        stall_req = 1'b1;
        offer_random_text(30);
        calm = 1'b0;
        drain_results();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: cap_val = 16'hFFFF;
                1: cap_val = 16'($urandom_range(0, 24));
                2: cap_val = 16'd256;
                3: cap_val = 16'd1;
                4: cap_val = 16'($urandom);
                default: cap_val = 16'd12;
            endcase
            calm = (phase == 2);
            write_capacity(cap_val);
            offer_random_text(70);
            drain_results();
        end
        calm = 1'b0;
        repeat (16) @(posedge clk);

        if (mismatches == 0 && due_count == 0)
            $display("** utf16le_to_utf8_transcoder: PASSED **");
        else
            $display("** utf16le_to_utf8_transcoder: FAILED **");
        $finish;
    end

endmodule
